FILE: hw/rtl/lpct_pkg.sv
// ----------------------------------------------------------------------------
// lpct_pkg
// Shared types and constants of the linear probing count table: field
// widths, action and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpct_pkg;

  localparam int KEY_W      = 32;
  localparam int CNT_W      = 32;
  // home slot unit: reciprocal multiply, then multiply-subtract
  localparam int DIV_CYCLES = 2;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_FULL  = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;     // write a zero entry at the sweep address
    logic start;        // capture input beat, arm home slot unit
    logic div_step;     // one home slot step
    logic home;         // load home slot, reset probe bookkeeping
    logic probe_issue;  // read the current slot, advance
    logic finish;       // commit update, load result register
  } lpct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;     // sweep at last slot
    logic div_last;     // last home slot step
    logic hit;          // compared slot holds key or is empty
    logic full;         // whole table probed without a hit
  } lpct_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lpct_ctrl.sv
// ----------------------------------------------------------------------------
// lpct_ctrl
// Controller: clear sweep after reset, input capture, remainder, probe loop
// and result hand-off to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpct_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  input  lpct_pkg::lpct_stat_t st,
  output lpct_pkg::lpct_cmd_t  cmd
);
  import lpct_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_HOME,
    S_PROBE,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // commands follow from state and status
  always_comb begin
    cmd             = '0;
    cmd.clear_wr    = (state_r == S_CLEAR);
    cmd.start       = (state_r == S_IDLE) && in_tvalid;
    cmd.div_step    = (state_r == S_DIV);
    cmd.home        = (state_r == S_HOME);
    cmd.probe_issue = (state_r == S_PROBE) && !st.hit && !st.full;
    cmd.finish      = (state_r == S_FINISH) && out_free;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      // a commit reloads the result register, else a taken beat empties it
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (st.clr_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (st.div_last) begin
            state_r <= S_HOME;
          end
        end
        S_HOME: begin
          state_r <= S_PROBE;
        end
        S_PROBE: begin
          if (st.hit || st.full) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lpct_dp.sv
// ----------------------------------------------------------------------------
// lpct_dp
// Datapath: slot memory, home slot remainder unit, probe address and
// compare, count update and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpct_dp #(
  parameter int TABLE_SIZE = 1024
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  lpct_pkg::lpct_cmd_t               cmd,
  output lpct_pkg::lpct_stat_t              st,
  input  wire                               in_action,
  input  wire  [lpct_pkg::KEY_W-1:0]        in_key,
  output logic [lpct_pkg::CNT_W-1:0]        out_count,
  output logic                              out_status
);
  import lpct_pkg::*;

  localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int RW = IW + 1;
  localparam logic [RW-1:0] TSIZE    = RW'(TABLE_SIZE);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
  localparam int EW = KEY_W + CNT_W;
  localparam int PW = 2 * KEY_W;
  // floor(2^32 / TABLE_SIZE): quotient estimate is exact or one low
  localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(TABLE_SIZE);
  localparam logic [KEY_W-1:0] RECIP   = KEY_W'(64'h1_0000_0000 / 64'(TABLE_SIZE));

  // slot memory: {count, key}
  logic [EW-1:0] mem [TABLE_SIZE];
  logic [EW-1:0] rdata_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  // captured beat
  logic             action_r;
  logic [KEY_W-1:0] key_r;

  // remainder unit
  logic [KEY_W-1:0]     mag_r;
  logic [KEY_W-1:0]     quo_r;
  logic [RW-1:0]        rem_est_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [PW-1:0]        quo_prod;
  logic [KEY_W-1:0]     rem_full;
  logic [IW-1:0]        rem;
  logic [KEY_W-1:0]     key_mag;
  logic [RW-1:0]        home_ext;

  // probe
  logic [IW-1:0] addr_r;
  logic [IW-1:0] addr_inc;
  logic [IW-1:0] cmp_addr_r;
  logic [IW-1:0] probe_cnt_r;
  logic          rd_pend_r;
  logic          found_r;
  logic [KEY_W-1:0] rkey;
  logic [CNT_W-1:0] rcnt;
  logic          hit;
  logic [CNT_W-1:0] new_cnt;

  // result register
  logic [CNT_W-1:0] out_count_r;
  logic             out_status_r;

  assign rkey = rdata_r[KEY_W-1:0];
  assign rcnt = rdata_r[EW-1:KEY_W];

  // magnitude of the signed key; the most negative key maps to 2^31
  assign key_mag = in_key[KEY_W-1] ? (~in_key + KEY_W'(1)) : in_key;

  // quotient estimate, then remainder in [0, 2*TABLE_SIZE)
  assign quo_prod = PW'(mag_r) * PW'(RECIP);
  assign rem_full = mag_r - quo_r * DIVISOR;

  // one correction step brings the remainder into range
  assign rem = (rem_est_r >= TSIZE) ? IW'(rem_est_r - TSIZE) : rem_est_r[IW-1:0];

  // negative keys fold back into [0, TABLE_SIZE)
  assign home_ext = (key_r[KEY_W-1] && (rem != '0)) ? (TSIZE - {1'b0, rem})
                                                    : {1'b0, rem};

  assign addr_inc = (addr_r == LAST_IDX) ? '0 : addr_r + IW'(1);

  // compare of the slot read in the previous cycle
  assign hit = rd_pend_r && ((rkey == key_r) || ((rkey == '0) && (rcnt == '0)));

  assign st.clr_last = (addr_r == LAST_IDX);
  assign st.div_last = (div_cnt_r == DIV_CNT_W'(DIV_CYCLES - 1));
  assign st.hit      = hit;
  assign st.full     = rd_pend_r && !hit && (probe_cnt_r == LAST_IDX);

  // saturating count update; an empty slot restarts at one
  always_comb begin
    if (rkey == key_r) begin
      new_cnt = (rcnt == CNT_MAX) ? rcnt : rcnt + CNT_W'(1);
    end else begin
      new_cnt = CNT_W'(1);
    end
  end

  // memory write port: clear sweep or insert commit
  assign mem_we    = cmd.clear_wr || (cmd.finish && found_r && (action_r == ACT_INSERT));
  assign mem_waddr = cmd.clear_wr ? addr_r : cmp_addr_r;
  assign mem_wdata = cmd.clear_wr ? '0 : {new_cnt, key_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_issue) begin
      rdata_r <= mem[addr_r];
    end
  end

  // probe bookkeeping and sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      rd_pend_r   <= 1'b0;
      probe_cnt_r <= '0;
      found_r     <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      if (cmd.clear_wr) begin
        addr_r <= addr_inc;
      end
      if (cmd.start) begin
        div_cnt_r <= '0;
      end
      if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      if (cmd.home) begin
        addr_r      <= home_ext[IW-1:0];
        probe_cnt_r <= '0;
        rd_pend_r   <= 1'b0;
        found_r     <= 1'b0;
      end else begin
        rd_pend_r <= cmd.probe_issue;
      end
      if (cmd.probe_issue) begin
        addr_r     <= addr_inc;
        cmp_addr_r <= addr_r;
      end
      if (rd_pend_r) begin
        probe_cnt_r <= probe_cnt_r + IW'(1);
        found_r     <= hit;
      end
    end
  end

  // captured beat and remainder registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      action_r <= in_action;
      key_r    <= in_key;
      mag_r    <= key_mag;
    end
    if (cmd.div_step) begin
      if (st.div_last) begin
        rem_est_r <= rem_full[RW-1:0];
      end else begin
        quo_r <= quo_prod[PW-1:KEY_W];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (action_r == ACT_INSERT) begin
        out_count_r  <= found_r ? new_cnt : '0;
        out_status_r <= found_r ? STAT_OK : STAT_FULL;
      end else begin
        out_count_r  <= found_r ? rcnt : '0;
        out_status_r <= STAT_OK;
      end
    end
  end

  assign out_count  = out_count_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

FILE: hw/rtl/linear_probe_count_table.sv
// ----------------------------------------------------------------------------
// linear_probe_count_table
// Counting hash table of signed 32-bit keys, open addressing with linear
// probing, saturating counts, bounded probe length.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: in_tuser = action (0 insert, 1 query), in_tdata = key.
//   Result beat: out_tdata = count, out_tuser = status (1: insert found the
//   table full). Exactly one result beat per input beat, in order.
//   After reset the block sweeps the slot memory to zero, one slot per
//   cycle; in_tready stays low during the sweep.
//   Per item: accept, home slot (reciprocal multiply, then
//   multiply-subtract), load of the home slot, then P probes (one slot
//   memory read per cycle, registered read data), and commit and load of
//   the result register. P runs from 1 up to TABLE_SIZE. One item is in
//   flight at a time. The result sits in an output register; the next
//   item is accepted while it waits. If the receiver stalls, the
//   following item holds in its commit cycle until the result register
//   frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_count_table #(
  parameter int TABLE_SIZE = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] key
  input  wire  [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [31:0] count
  output logic [0:0]  out_tuser   // [0] status
);
  import lpct_pkg::*;

  lpct_cmd_t  cmd;
  lpct_stat_t st;

  lpct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  lpct_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_action  (in_tuser[0]),
    .in_key     (in_tdata),
    .out_count  (out_tdata),
    .out_status (out_tuser[0])
  );

endmodule

`default_nettype wire

FILE: hw/rtl/lpct_checker.sv
// ----------------------------------------------------------------------------
// lpct_checker
// Port-level checks of the count table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpct_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [31:0] in_tdata,
  input wire [0:0]  in_tuser,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire [0:0]  out_tuser
);

  // input beat holds while it waits
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && !in_tready) |=> (in_tvalid && $stable(in_tdata) && $stable(in_tuser)))
    else $error("input beat changed while waiting");

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result beat changed under stall");

  // a full-table failure carries count zero
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 32'd0))
    else $error("full status with nonzero count");

  // one item in flight: no back-to-back accepts
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted in consecutive cycles");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind linear_probe_count_table lpct_checker u_lpct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
